// ===== src/lgpb_pkg.sv =====
// lgpb_pkg: shared types, constants and blend arithmetic for the gradient blend
// used by lgpb_weight, lgpb_mix and linear_gradient_pixel_blend
// no dependencies
package lgpb_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int POS_W     = 12;
    localparam int COL_W     = 8;
    localparam int SLOPE_W   = 32;
    localparam int WGT_FRAC  = 16;
    localparam int WGT_W     = WGT_FRAC + 1;
    localparam int XPROD_W   = POS_W + 1 + SLOPE_W;
    localparam int SUM_W     = XPROD_W + 2;
    localparam int DIFF_W    = COL_W + 1;
    localparam int PROD_W    = WGT_W + 1 + DIFF_W;
    localparam int NUM_CH    = 4;
    localparam int CFG_IDX_W = 8;

    localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(1) << WGT_FRAC;
    localparam logic [16:0]      POS_MAX    = 17'(MAX_DIM - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_X_SLOPE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SLOPE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_EN = 8'd3;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
        logic [COL_W-1:0] alpha;
    } t_rgba;

    typedef struct packed {
        t_rgba first;
        t_rgba second;
    } t_pix;

    // saturate a position to the image bound
    function automatic logic [POS_W-1:0] clamp_pos(logic [POS_W-1:0] p);
        if (17'(p) > POS_MAX) begin
            return POS_W'(POS_MAX);
        end
        return p;
    endfunction

    // weight times channel difference
    function automatic logic signed [PROD_W-1:0] blend_prod(logic [WGT_W-1:0] w,
                                                            logic [COL_W-1:0] a,
                                                            logic [COL_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        logic signed [WGT_W:0]    ws;
        d  = $signed({1'b0, b}) - $signed({1'b0, a});
        ws = $signed({1'b0, w});
        return ws * d;
    endfunction

    // divide by one with truncation toward zero, then add the first channel
    function automatic logic [COL_W-1:0] blend_fin(logic signed [PROD_W-1:0] prod,
                                                   logic [COL_W-1:0] a);
        logic signed [PROD_W-1:0] adj;
        adj = prod;
        if (prod[PROD_W-1]) begin
            adj = prod + $signed(PROD_W'(WEIGHT_ONE - WGT_W'(1)));
        end
        return COL_W'(a + adj[WGT_FRAC +: COL_W]);
    endfunction

endpackage

// ===== src/linear_gradient_pixel_blend.sv =====
// linear_gradient_pixel_blend: top level with configuration registers
// instantiates lgpb_weight and lgpb_mix, depends on lgpb_pkg
//
// usage
//   input channel i_valid/o_ready carries one word: pixel position and two
//   rgba pixels. output channel o_valid/i_ready carries the blended rgba word.
//   configuration channel i_cfg_valid/o_cfg_ready writes i_cfg_data to the
//   register at i_cfg_index (x slope, y slope, offset, alpha enable); it is
//   always ready, unknown indexes are dropped. write it only while idle.
//   four register stages: position times slope, sum and clamp of the weight,
//   weight times channel difference, divide and add into the output register.
//   one word per cycle is sustained while the receiver keeps i_ready high;
//   when the receiver holds i_ready low the stages fill and o_ready falls only
//   once all four hold a word; nothing is lost or repeated.
//   reset empties the pipeline and clears all configuration registers to zero.
module linear_gradient_pixel_blend (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lgpb_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lgpb_pkg::SLOPE_W-1:0]          i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [lgpb_pkg::POS_W-1:0]            i_pos_x,
    input  logic [lgpb_pkg::POS_W-1:0]            i_pos_y,
    input  logic [lgpb_pkg::COL_W-1:0]            i_first_red,
    input  logic [lgpb_pkg::COL_W-1:0]            i_first_green,
    input  logic [lgpb_pkg::COL_W-1:0]            i_first_blue,
    input  logic [lgpb_pkg::COL_W-1:0]            i_first_alpha,
    input  logic [lgpb_pkg::COL_W-1:0]            i_second_red,
    input  logic [lgpb_pkg::COL_W-1:0]            i_second_green,
    input  logic [lgpb_pkg::COL_W-1:0]            i_second_blue,
    input  logic [lgpb_pkg::COL_W-1:0]            i_second_alpha,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [lgpb_pkg::COL_W-1:0]            o_out_red,
    output logic [lgpb_pkg::COL_W-1:0]            o_out_green,
    output logic [lgpb_pkg::COL_W-1:0]            o_out_blue,
    output logic [lgpb_pkg::COL_W-1:0]            o_out_alpha
);
    import lgpb_pkg::*;

    logic signed [SLOPE_W-1:0] r_x_slope;
    logic signed [SLOPE_W-1:0] r_y_slope;
    logic signed [SLOPE_W-1:0] r_offset;
    logic                      r_alpha_en;
    logic [2:0]                r_occ;

    t_pix             w_pix;
    logic             w_wgt_valid;
    logic             w_wgt_ready;
    logic [WGT_W-1:0] w_wgt;
    t_pix             w_wgt_pix;
    t_rgba            w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_slope  <= '0;
            r_y_slope  <= '0;
            r_offset   <= '0;
            r_alpha_en <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_X_SLOPE:  r_x_slope  <= $signed(i_cfg_data);
                CFG_Y_SLOPE:  r_y_slope  <= $signed(i_cfg_data);
                CFG_OFFSET:   r_offset   <= $signed(i_cfg_data);
                CFG_ALPHA_EN: r_alpha_en <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign w_pix.first.red    = i_first_red;
    assign w_pix.first.green  = i_first_green;
    assign w_pix.first.blue   = i_first_blue;
    assign w_pix.first.alpha  = i_first_alpha;
    assign w_pix.second.red   = i_second_red;
    assign w_pix.second.green = i_second_green;
    assign w_pix.second.blue  = i_second_blue;
    assign w_pix.second.alpha = i_second_alpha;

    lgpb_weight u_weight (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pix     (w_pix),
        .i_x_slope (r_x_slope),
        .i_y_slope (r_y_slope),
        .i_offset  (r_offset),
        .o_valid   (w_wgt_valid),
        .i_ready   (w_wgt_ready),
        .o_weight  (w_wgt),
        .o_pix     (w_wgt_pix)
    );

    lgpb_mix u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_wgt_valid),
        .o_ready    (w_wgt_ready),
        .i_weight   (w_wgt),
        .i_pix      (w_wgt_pix),
        .i_alpha_en (r_alpha_en),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rgba     (w_out)
    );

    assign o_out_red   = w_out.red;
    assign o_out_green = w_out.green;
    assign o_out_blue  = w_out.blue;
    assign o_out_alpha = w_out.alpha;

    // words in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= r_occ + 3'(i_valid && o_ready) - 3'(o_valid && i_ready);
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= 3'd4)
        else $error("more words in flight than pipeline stages");

    a_out_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_occ != 3'd0)
        else $error("output word without an accepted input");

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output stage is empty");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wgt_valid |-> w_wgt <= WEIGHT_ONE)
        else $error("blend weight above one");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && r_occ == 3'd0)
        else $error("pipeline not empty after reset");

endmodule

// ===== src/lgpb_weight.sv =====
// lgpb_weight: two pipeline stages forming the clamped 1.16 blend weight
// stage one multiplies position by slope, stage two sums and clamps
// depends on lgpb_pkg
module lgpb_weight (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [lgpb_pkg::POS_W-1:0]          i_pos_x,
    input  logic [lgpb_pkg::POS_W-1:0]          i_pos_y,
    input  lgpb_pkg::t_pix                      i_pix,
    input  logic signed [lgpb_pkg::SLOPE_W-1:0] i_x_slope,
    input  logic signed [lgpb_pkg::SLOPE_W-1:0] i_y_slope,
    input  logic signed [lgpb_pkg::SLOPE_W-1:0] i_offset,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [lgpb_pkg::WGT_W-1:0]          o_weight,
    output lgpb_pkg::t_pix                      o_pix
);
    import lgpb_pkg::*;

    logic                      r_s1_vld;
    logic signed [XPROD_W-1:0] r_s1_xprod;
    logic signed [XPROD_W-1:0] r_s1_yprod;
    t_pix                      r_s1_pix;
    logic                      r_s2_vld;
    logic [WGT_W-1:0]          r_s2_wgt;
    t_pix                      r_s2_pix;

    logic                      w_en1;
    logic                      w_en2;
    logic signed [XPROD_W-1:0] n_xprod;
    logic signed [XPROD_W-1:0] n_yprod;
    logic signed [SUM_W-1:0]   w_sum;
    logic [WGT_W-1:0]          n_wgt;

    assign w_en2   = !r_s2_vld || i_ready;
    assign w_en1   = !r_s1_vld || w_en2;
    assign o_ready = w_en1;

    always_comb begin
        n_xprod = $signed({1'b0, clamp_pos(i_pos_x)}) * i_x_slope;
        n_yprod = $signed({1'b0, clamp_pos(i_pos_y)}) * i_y_slope;
    end

    always_comb begin
        w_sum = SUM_W'(r_s1_xprod) + SUM_W'(r_s1_yprod) + SUM_W'(i_offset);
        if (w_sum[SUM_W-1]) begin
            n_wgt = '0;
        end else if (w_sum > $signed(SUM_W'(WEIGHT_ONE))) begin
            n_wgt = WEIGHT_ONE;
        end else begin
            n_wgt = w_sum[WGT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_vld <= i_valid;
            end
            if (w_en2) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_xprod <= n_xprod;
            r_s1_yprod <= n_yprod;
            r_s1_pix   <= i_pix;
        end
        if (w_en2) begin
            r_s2_wgt <= n_wgt;
            r_s2_pix <= r_s1_pix;
        end
    end

    assign o_valid  = r_s2_vld;
    assign o_weight = r_s2_wgt;
    assign o_pix    = r_s2_pix;

endmodule

// ===== src/lgpb_mix.sv =====
// lgpb_mix: two pipeline stages blending red, green, blue (and alpha when i_alpha_en is set) by the weight
// stage one forms weight times difference, stage two divides and adds
// depends on lgpb_pkg
module lgpb_mix (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [lgpb_pkg::WGT_W-1:0] i_weight,
    input  lgpb_pkg::t_pix             i_pix,
    input  logic                       i_alpha_en,
    output logic                       o_valid,
    input  logic                       i_ready,
    output lgpb_pkg::t_rgba            o_rgba
);
    import lgpb_pkg::*;

    logic                     r_a_vld;
    logic signed [PROD_W-1:0] r_a_prod [NUM_CH];
    t_rgba                    r_a_first;
    logic                     r_b_vld;
    t_rgba                    r_b_rgba;

    logic                     w_ena;
    logic                     w_enb;
    logic [COL_W-1:0]         w_p1 [NUM_CH];
    logic [COL_W-1:0]         w_p2 [NUM_CH];
    logic signed [PROD_W-1:0] n_prod [NUM_CH];
    t_rgba                    n_rgba;

    assign w_enb   = !r_b_vld || i_ready;
    assign w_ena   = !r_a_vld || w_enb;
    assign o_ready = w_ena;

    always_comb begin
        w_p1[CH_RED]   = i_pix.first.red;
        w_p1[CH_GREEN] = i_pix.first.green;
        w_p1[CH_BLUE]  = i_pix.first.blue;
        w_p1[CH_ALPHA] = i_pix.first.alpha;
        w_p2[CH_RED]   = i_pix.second.red;
        w_p2[CH_GREEN] = i_pix.second.green;
        w_p2[CH_BLUE]  = i_pix.second.blue;
        w_p2[CH_ALPHA] = i_pix.second.alpha;
        for (int i = 0; i < NUM_CH; i++) begin
            n_prod[i] = blend_prod(i_weight, w_p1[i], w_p2[i]);
        end
    end

    always_comb begin
        n_rgba.red   = blend_fin(r_a_prod[CH_RED], r_a_first.red);
        n_rgba.green = blend_fin(r_a_prod[CH_GREEN], r_a_first.green);
        n_rgba.blue  = blend_fin(r_a_prod[CH_BLUE], r_a_first.blue);
        if (i_alpha_en) begin
            n_rgba.alpha = blend_fin(r_a_prod[CH_ALPHA], r_a_first.alpha);
        end else begin
            n_rgba.alpha = r_a_first.alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (w_ena) begin
                r_a_vld <= i_valid;
            end
            if (w_enb) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ena) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_a_prod[i] <= n_prod[i];
            end
            r_a_first <= i_pix.first;
        end
        if (w_enb) begin
            r_b_rgba <= n_rgba;
        end
    end

    assign o_valid = r_b_vld;
    assign o_rgba  = r_b_rgba;

endmodule
